// File: rtl/core/rc4c_pkg.sv
`default_nettype none

package rc4c_pkg;

   localparam int BYTE_W      = 8;
   localparam int PERM_DEPTH  = 256;
   localparam int PERM_AW     = 8;
   localparam int KEY_MAX_DEF = 256;

   localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_DEPTH - 1);

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_DATA = 1'b1;

   localparam logic [1:0] ST_DATA_OK  = 2'd0;
   localparam logic [1:0] ST_KEY_SET  = 2'd1;
   localparam logic [1:0] ST_KEY_LONG = 2'd2;
   localparam logic [1:0] ST_NO_KEY   = 2'd3;

   typedef struct packed {
      logic              opcode;
      logic [BYTE_W-1:0] value;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic full;
      logic overflow;
   } ks_stat_type;

endpackage

`default_nettype wire

// File: rtl/core/rc4c_keystore.sv
`default_nettype none

module rc4c_keystore #(
   parameter int KEY_MAX = rc4c_pkg::KEY_MAX_DEF,
   parameter int KCW     = $clog2(KEY_MAX + 1),
   parameter int KAW     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             wr_en,
   input  wire                             wr_last,
   input  wire  [rc4c_pkg::BYTE_W-1:0]     wr_value,
   input  wire  [KAW-1:0]                  rd_addr,
   output logic [rc4c_pkg::BYTE_W-1:0]     rd_data,
   output rc4c_pkg::ks_stat_type           stat,
   output logic [KCW-1:0]                  key_len
);

   logic [rc4c_pkg::BYTE_W-1:0] key_mem [0:KEY_MAX-1];
   logic [rc4c_pkg::BYTE_W-1:0] rd_data_ff;
   logic [KCW-1:0]              count_ff;
   logic [KCW-1:0]              count_in;
   logic                        ovf_ff;
   logic                        ovf_in;
   logic                        full;

   assign full          = (count_ff >= KCW'(KEY_MAX));
   assign stat.full     = full;
   assign stat.overflow = ovf_ff | full;
   assign key_len       = count_ff + KCW'(1);
   assign rd_data       = rd_data_ff;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (wr_en) begin
         if (wr_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
         end else if (full) begin
            ovf_in = 1'b1;
         end else begin
            count_in = count_ff + KCW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !full) begin
         key_mem[count_ff[KAW-1:0]] <= wr_value;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/rc4c_engine.sv
`default_nettype none

module rc4c_engine #(
   parameter int KEY_MAX = rc4c_pkg::KEY_MAX_DEF,
   parameter int KCW     = $clog2(KEY_MAX + 1),
   parameter int KAW     = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             in_accept,
   input  rc4c_pkg::req_type               in_item,
   input  rc4c_pkg::ks_stat_type           ks_stat,
   input  wire  [KCW-1:0]                  key_len,
   input  wire  [rc4c_pkg::BYTE_W-1:0]     key_rdata,
   output logic [KAW-1:0]                  key_addr,
   input  wire                             rsp_free,
   output logic                            busy,
   output logic                            res_valid,
   output rc4c_pkg::rsp_type               res
);

   localparam int PAW = rc4c_pkg::PERM_AW;
   localparam int BW  = rc4c_pkg::BYTE_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_MIX_A = 4'd2;
   localparam logic [3:0] S_MIX_B = 4'd3;
   localparam logic [3:0] S_MIX_C = 4'd4;
   localparam logic [3:0] S_MIX_D = 4'd5;
   localparam logic [3:0] S_DAT_1 = 4'd6;
   localparam logic [3:0] S_DAT_2 = 4'd7;
   localparam logic [3:0] S_DAT_3 = 4'd8;
   localparam logic [3:0] S_DAT_4 = 4'd9;
   localparam logic [3:0] S_DAT_5 = 4'd10;
   localparam logic [3:0] S_EMIT  = 4'd11;

   logic [BW-1:0]  perm_mem [0:rc4c_pkg::PERM_DEPTH-1];
   logic [BW-1:0]  perm_rd_ff;
   logic [PAW-1:0] perm_addr;
   logic           perm_we;
   logic [BW-1:0]  perm_wdata;

   logic [3:0]        state_ff, state_in;
   logic [PAW-1:0]    n_ff, n_in;
   logic [BW-1:0]     acc_ff, acc_in;
   logic [KCW-1:0]    kidx_ff, kidx_in;
   logic [KCW-1:0]    len_ff, len_in;
   logic [KCW-1:0]    kidx_inc;
   logic [PAW-1:0]    i_ff, i_in;
   logic [PAW-1:0]    j_ff, j_in;
   logic [BW-1:0]     hold_ff, hold_in;
   logic [BW-1:0]     sj_ff, sj_in;
   logic [BW-1:0]     value_ff, value_in;
   logic              last_ff, last_in;
   logic              loaded_ff, loaded_in;
   rc4c_pkg::rsp_type res_ff, res_in;
   logic [BW-1:0]     mix_sum;
   logic [PAW-1:0]    j_sum;
   logic [PAW-1:0]    out_idx;

   assign key_addr  = kidx_ff[KAW-1:0];
   assign busy      = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_EMIT);
   assign res       = res_ff;

   assign mix_sum  = acc_ff + perm_rd_ff + key_rdata;
   assign j_sum    = j_ff + perm_rd_ff;
   assign out_idx  = hold_ff + sj_ff;
   assign kidx_inc = kidx_ff + KCW'(1);

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      acc_in     = acc_ff;
      kidx_in    = kidx_ff;
      len_in     = len_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      hold_in    = hold_ff;
      sj_in      = sj_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      loaded_in  = loaded_ff;
      res_in     = res_ff;
      perm_addr  = i_ff + PAW'(1);
      perm_we    = 1'b0;
      perm_wdata = n_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (in_accept) begin
               value_in = in_item.value;
               last_in  = in_item.last;
               if (in_item.opcode == rc4c_pkg::OP_KEY) begin
                  if (in_item.last) begin
                     res_in.out_byte = '0;
                     if (ks_stat.overflow) begin
                        res_in.status = rc4c_pkg::ST_KEY_LONG;
                        state_in      = S_EMIT;
                     end else begin
                        len_in   = key_len;
                        n_in     = '0;
                        state_in = S_INIT;
                     end
                  end
               end else if (!loaded_ff) begin
                  res_in.out_byte = '0;
                  res_in.status   = rc4c_pkg::ST_NO_KEY;
                  state_in        = S_EMIT;
               end else begin
                  i_in     = i_ff + PAW'(1);
                  state_in = S_DAT_1;
               end
            end
         end
         S_INIT: begin
            perm_addr  = n_ff;
            perm_we    = 1'b1;
            perm_wdata = n_ff;
            n_in       = n_ff + PAW'(1);
            if (n_ff == rc4c_pkg::PERM_LAST) begin
               acc_in   = '0;
               kidx_in  = '0;
               state_in = S_MIX_A;
            end
         end
         S_MIX_A: begin
            perm_addr = n_ff;
            state_in  = S_MIX_B;
         end
         S_MIX_B: begin
            perm_addr = mix_sum;
            hold_in   = perm_rd_ff;
            acc_in    = mix_sum;
            state_in  = S_MIX_C;
         end
         S_MIX_C: begin
            perm_addr  = n_ff;
            perm_we    = 1'b1;
            perm_wdata = perm_rd_ff;
            state_in   = S_MIX_D;
         end
         S_MIX_D: begin
            perm_addr  = acc_ff;
            perm_we    = 1'b1;
            perm_wdata = hold_ff;
            n_in       = n_ff + PAW'(1);
            kidx_in    = (kidx_inc == len_ff) ? '0 : kidx_inc;
            if (n_ff == rc4c_pkg::PERM_LAST) begin
               loaded_in       = 1'b1;
               i_in            = '0;
               j_in            = '0;
               res_in.out_byte = '0;
               res_in.status   = rc4c_pkg::ST_KEY_SET;
               state_in        = S_EMIT;
            end else begin
               state_in = S_MIX_A;
            end
         end
         S_DAT_1: begin
            perm_addr = j_sum;
            hold_in   = perm_rd_ff;
            j_in      = j_sum;
            state_in  = S_DAT_2;
         end
         S_DAT_2: begin
            perm_addr  = i_ff;
            perm_we    = 1'b1;
            perm_wdata = perm_rd_ff;
            sj_in      = perm_rd_ff;
            state_in   = S_DAT_3;
         end
         S_DAT_3: begin
            perm_addr  = j_ff;
            perm_we    = 1'b1;
            perm_wdata = hold_ff;
            state_in   = S_DAT_4;
         end
         S_DAT_4: begin
            perm_addr = out_idx;
            state_in  = S_DAT_5;
         end
         S_DAT_5: begin
            res_in.out_byte = value_ff ^ perm_rd_ff;
            res_in.status   = rc4c_pkg::ST_DATA_OK;
            if (last_ff) begin
               i_in = '0;
               j_in = '0;
            end
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         loaded_ff <= 1'b0;
         i_ff      <= '0;
         j_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         loaded_ff <= loaded_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff     <= n_in;
      acc_ff   <= acc_in;
      kidx_ff  <= kidx_in;
      len_ff   <= len_in;
      hold_ff  <= hold_in;
      sj_ff    <= sj_in;
      value_ff <= value_in;
      last_ff  <= last_in;
      res_ff   <= res_in;
   end

   always_ff @(posedge clock) begin
      if (perm_we) begin
         perm_mem[perm_addr] <= perm_wdata;
      end
      perm_rd_ff <= perm_mem[perm_addr];
   end

endmodule

`default_nettype wire

// File: rtl/core/rc4_stream_cipher_top.sv
// RC4 cipher engine built around one single-port 256-entry permutation memory that a small
// sequencer walks through. A key byte that is not the last one only goes into the key store.
// The last byte of a key that fits the store runs the key schedule: it loads the identity,
// then makes four memory accesses for each of the 256 mixing steps, then gives the status
// item. A data byte needs five dependent reads and writes of the permutation memory plus
// accept and result. The block takes no new item while one is in work; a finished result
// waits in the output register, so the next item is accepted while it is still stalled.
`default_nettype none

module rc4_stream_cipher_top #(
   parameter int KEY_MAX = rc4c_pkg::KEY_MAX_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  rc4c_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output rc4c_pkg::rsp_type  rsp_data
);

   localparam int KCW = $clog2(KEY_MAX + 1);
   localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

   logic                        in_accept;
   logic                        busy;
   logic                        res_valid;
   rc4c_pkg::rsp_type           res;
   logic                        rsp_free;
   rc4c_pkg::ks_stat_type       ks_stat;
   logic [KCW-1:0]              key_len;
   logic [KAW-1:0]              key_addr;
   logic [rc4c_pkg::BYTE_W-1:0] key_rdata;
   logic                        rsp_valid_ff, rsp_valid_in;
   rc4c_pkg::rsp_type           rsp_data_ff;

   assign req_stall = busy;
   assign in_accept = req_valid && !busy;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   rc4c_keystore #(
      .KEY_MAX (KEY_MAX),
      .KCW     (KCW),
      .KAW     (KAW)
   ) u_keystore (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (in_accept && (req_data.opcode == rc4c_pkg::OP_KEY)),
      .wr_last  (req_data.last),
      .wr_value (req_data.value),
      .rd_addr  (key_addr),
      .rd_data  (key_rdata),
      .stat     (ks_stat),
      .key_len  (key_len)
   );

   rc4c_engine #(
      .KEY_MAX (KEY_MAX),
      .KCW     (KCW),
      .KAW     (KAW)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_accept (in_accept),
      .in_item   (req_data),
      .ks_stat   (ks_stat),
      .key_len   (key_len),
      .key_rdata (key_rdata),
      .key_addr  (key_addr),
      .rsp_free  (rsp_free),
      .busy      (busy),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && rsp_free) begin
         rsp_data_ff <= res;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/rc4c_checker.sv
`default_nettype none

module rc4c_checker (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input rc4c_pkg::req_type req_data,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input rc4c_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != rc4c_pkg::ST_DATA_OK) |-> (rsp_data.out_byte == '0))
      else $error("status item carries a nonzero byte");

   a_data_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == rc4c_pkg::OP_DATA) |=> req_stall)
      else $error("ready right after a data item");

   a_key_fast: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.opcode == rc4c_pkg::OP_KEY) && !req_data.last
      |=> !req_stall)
      else $error("not ready after a key byte that is not the last");

endmodule

bind rc4_stream_cipher_top rc4c_checker u_rc4c_checker (.*);

`default_nettype wire
